// ===== src/mjt_pkg.sv =====
// ----------------------------------------------------------------------------
// mjt_pkg
// Shared types and constants of the minimum-jerk trajectory generator.
// ----------------------------------------------------------------------------
package mjt_pkg;

    localparam logic [15:0] STEP_COUNT_RESET = 16'd1000;
    localparam logic [16:0] Q16_ONE          = 17'h10000;
    localparam int          DIV_STEPS        = 16;
    localparam int          DIV_CNT_W        = $clog2(DIV_STEPS + 1);
    localparam logic [20:0] K_TEN            = 21'd655360;
    localparam logic [20:0] K_SIX            = 21'd6;
    localparam logic [20:0] K_FIFTEEN        = 21'd15;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic signed [23:0] start;
        logic signed [24:0] delta;
    } mjt_entry_t;

endpackage

// ===== src/mjt_div.sv =====
// ----------------------------------------------------------------------------
// mjt_div
// Restoring divider that returns floor(dividend * 65536 / divisor), one
// quotient bit per cycle, for a dividend below the divisor.
// ----------------------------------------------------------------------------
module mjt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);
    import mjt_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          quo_reg, quo_next;
    logic [15:0]          div_reg, div_next;
    logic [16:0]          trial;
    logic                 fits;

    assign trial = {rem_reg, 1'b0};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            rem_next  = dividend;
            quo_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
            quo_next = {quo_reg[14:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while still busy");
`endif

endmodule

// ===== src/mjt_poly.sv =====
// ----------------------------------------------------------------------------
// mjt_poly
// Three-stage evaluation of the blend 10s^3 - 15s^4 + 6s^5 in Q0.16.
// ----------------------------------------------------------------------------
module mjt_poly (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [15:0] s,
    output logic        out_valid,
    output logic [16:0] p
);
    import mjt_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    logic [31:0] m1_reg, m1_next;
    logic [15:0] s1_reg;
    logic [31:0] m2_reg, m2_next;
    logic [19:0] k_reg, k_next;
    logic [35:0] m3_reg, m3_next;
    logic [15:0] s2;
    logic [20:0] k_full;

    assign m1_next = s * s;
    assign s2      = m1_reg[31:16];
    assign m2_next = s2 * s1_reg;
    assign k_full  = K_TEN + 21'(s2) * K_SIX - 21'(s1_reg) * K_FIFTEEN;
    assign k_next  = k_full[19:0];
    assign m3_next = 36'(m2_reg[31:16]) * 36'(k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= m1_next;
        s1_reg <= s;
        m2_reg <= m2_next;
        k_reg  <= k_next;
        m3_reg <= m3_next;
    end

    assign out_valid = v3_reg;
    assign p         = m3_reg[32:16];

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0({v1_reg, v2_reg, v3_reg}))
        else $error("more than one sample in the blend pipeline");
    assert property (@(posedge clk) disable iff (!rst_n) v3_reg |-> m3_reg[35:16] <= 20'(Q16_ONE))
        else $error("blend exceeds one");
`endif

endmodule

// ===== src/mjt_axis_mem.sv =====
// ----------------------------------------------------------------------------
// mjt_axis_mem
// Per-axis start and delta store with one write and one registered read port.
// Entries never loaded read as zero.
// ----------------------------------------------------------------------------
module mjt_axis_mem #(
    parameter int AXES = 4,
    parameter int AW   = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  mjt_pkg::mjt_entry_t wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output mjt_pkg::mjt_entry_t rd_data
);
    import mjt_pkg::*;

    mjt_entry_t            mem [AXES];
    logic [AXES-1:0]       loaded_reg;
    mjt_entry_t            rd_data_reg;
    logic                  rd_loaded_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            rd_loaded_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                loaded_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_loaded_reg <= loaded_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_loaded_reg ? rd_data_reg : '0;

endmodule

// ===== src/minimum_jerk_trajectory.sv =====
// ----------------------------------------------------------------------------
// minimum_jerk_trajectory
// A load beat leaves the block idle and ready for the next beat; a tick
// beat keeps the input not ready while the bit-serial divider, the
// three-stage blend and, per axis, a memory read, a multiply and an output
// load run, and output stalls hold it longer. A tick past the end of the
// move skips the divider and the blend. Reset clears the sample index, sets
// the step count to 1000 and makes every axis read as zero until loaded.
// ----------------------------------------------------------------------------
module minimum_jerk_trajectory #(
    parameter int AXES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,       // step_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // axis_select, start_position, goal_position
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // axis_index, sample_number, position
    output logic        m_axis_tlast,   // last_axis
    output logic        m_axis_tuser    // done_res
);
    import mjt_pkg::*;

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic [AW-1:0] LAST_AXIS = AW'(AXES - 1);
    localparam logic [3:0]    AXES_W4   = 4'(AXES);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_POLY = 6'b000100,
        ST_RD   = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [15:0]        step_count_reg, step_count_next;
    logic [15:0]        sample_index_reg, sample_index_next;
    logic [15:0]        cur_index_reg, cur_index_next;
    logic               cur_done_reg, cur_done_next;
    logic [AW-1:0]      axis_reg, axis_next;
    logic [16:0]        p_reg, p_next;
    logic signed [42:0] prod_reg, prod_next;
    logic [23:0]        start_reg, start_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_axis_reg;
    logic [15:0]        out_index_reg;
    logic [23:0]        out_pos_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    logic               in_fire, tick_fire, load_fire, sel_ok, emit_load;
    logic [1:0]         in_sel;
    logic signed [23:0] in_start, in_goal;
    logic [15:0]        step_n;
    logic               now_done;
    logic               div_start, div_done, poly_valid;
    logic [15:0]        div_q;
    logic [16:0]        poly_p;
    mjt_entry_t         wr_entry, rd_entry;
    logic               rd_en;

    assign in_sel    = s_axis_tdata[1:0];
    assign in_start  = s_axis_tdata[25:2];
    assign in_goal   = s_axis_tdata[49:26];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign tick_fire = in_fire && (s_axis_tuser == OP_TICK);
    assign sel_ok    = {2'b00, in_sel} < AXES_W4;
    assign load_fire = in_fire && (s_axis_tuser == OP_LOAD) && sel_ok;
    assign step_n    = (step_count_reg == 16'd0) ? 16'd1 : step_count_reg;
    assign now_done  = sample_index_reg >= step_n;
    assign cfg_ready = 1'b1;

    assign wr_entry.start = in_start;
    assign wr_entry.delta = 25'(in_goal) - 25'(in_start);

    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);
    assign div_start = tick_fire && !now_done;
    assign rd_en     = (state_reg == ST_RD);

    mjt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sample_index_reg),
        .divisor  (step_n),
        .done     (div_done),
        .quotient (div_q)
    );

    mjt_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_done),
        .s         (div_q),
        .out_valid (poly_valid),
        .p         (poly_p)
    );

    mjt_axis_mem #(
        .AXES (AXES),
        .AW   (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_fire),
        .wr_addr (AW'(in_sel)),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (axis_reg),
        .rd_data (rd_entry)
    );

    assign prod_next  = rd_entry.delta * $signed({1'b0, p_reg});
    assign start_next = rd_entry.start;

    always_comb
    begin
        state_next        = state_reg;
        step_count_next   = step_count_reg;
        sample_index_next = sample_index_reg;
        cur_index_next    = cur_index_reg;
        cur_done_next     = cur_done_reg;
        axis_next         = axis_reg;
        p_next            = p_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;

        if (cfg_valid && cfg_ready)
        begin
            step_count_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_fire)
                begin
                    sample_index_next = '0;
                end
                else if (tick_fire)
                begin
                    cur_index_next = sample_index_reg;
                    cur_done_next  = now_done;
                    axis_next      = '0;
                    if (now_done)
                    begin
                        p_next     = Q16_ONE;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        sample_index_next = sample_index_reg + 16'd1;
                        state_next        = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_POLY;
                end
            end
            ST_POLY:
            begin
                if (poly_valid)
                begin
                    p_next     = poly_p;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    if (axis_reg == LAST_AXIS)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_count_reg   <= STEP_COUNT_RESET;
            sample_index_reg <= '0;
            out_valid_reg    <= 1'b0;
            axis_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            step_count_reg   <= step_count_next;
            sample_index_reg <= sample_index_next;
            out_valid_reg    <= out_valid_next;
            axis_reg         <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_index_reg <= cur_index_next;
        cur_done_reg  <= cur_done_next;
        p_reg         <= p_next;
        if (state_reg == ST_MUL)
        begin
            prod_reg  <= prod_next;
            start_reg <= start_next;
        end
        if (emit_load)
        begin
            out_axis_reg  <= 2'(axis_reg);
            out_index_reg <= cur_index_reg;
            out_pos_reg   <= start_reg + prod_reg[39:16];
            out_last_reg  <= (axis_reg == LAST_AXIS);
            out_done_reg  <= cur_done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_pos_reg, out_index_reg, out_axis_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire && now_done |=> state_reg == ST_RD && p_reg == Q16_ONE)
        else $error("finished move did not bypass the divider");
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire && !now_done |=> sample_index_reg == $past(sample_index_reg) + 16'd1)
        else $error("sample index did not advance");
`endif

endmodule

// ===== bench/minimum_jerk_trajectory_check.sv =====
// ----------------------------------------------------------------------------
// minimum_jerk_trajectory_check
// Watches the configuration, input and output channels of the trajectory
// generator, keeps its own copy of the axis endpoints, the sample index and
// the step count, predicts one position per axis for every tick beat and compares
// each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module minimum_jerk_trajectory_check #(
    parameter int AXES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        m_axis_tuser,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mjt_pkg::*;

    typedef struct packed {
        logic [1:0]         axis;
        logic [15:0]        sample;
        logic signed [23:0] pos;
        logic               last;
        logic               done;
    } axis_sample_t;

    axis_sample_t       planned_samples[$];
    logic signed [23:0] start_pos[AXES];
    logic signed [24:0] span[AXES];
    logic [15:0]        sample_idx;
    logic [15:0]        move_steps;
    int                 errors;

    // Quintic blend 10s^3 - 15s^4 + 6s^5 with s and the result in Q0.16.
    function automatic longint unsigned blend_q16(input longint unsigned s);
        longint unsigned s2;
        longint unsigned s3;
        longint unsigned k;
        s2 = (s * s) >> 16;
        s3 = (s2 * s) >> 16;
        k  = 10 * 65536 + 6 * s2 - 15 * s;
        return (s3 * k) >> 16;
    endfunction

    task automatic predict_tick();
        int unsigned     n;
        int unsigned     i;
        logic            done;
        longint unsigned p;
        longint          pos;
        axis_sample_t    want;
        n    = (move_steps == 16'd0) ? 1 : move_steps;
        i    = sample_idx;
        done = (i >= n);
        p    = done ? 0 : blend_q16((longint'(i) << 16) / n);
        for (int a = 0; a < AXES; a++)
        begin
            if (done)
                pos = longint'(start_pos[a]) + longint'(span[a]);
            else
                pos = longint'(start_pos[a]) + ((longint'(span[a]) * longint'(p)) >>> 16);
            want.axis   = 2'(a);
            want.sample = 16'(i);
            want.pos    = 24'(pos);
            want.last   = (a == AXES - 1);
            want.done   = done;
            planned_samples.push_back(want);
        end
        if (i < n)
            sample_idx = 16'(i + 1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [1:0]         sel;
        logic signed [23:0] st;
        logic signed [23:0] gl;
        axis_sample_t       got;
        axis_sample_t       want;
        if (!rst_n)
        begin
            planned_samples.delete();
            for (int a = 0; a < AXES; a++)
            begin
                start_pos[a] = '0;
                span[a]      = '0;
            end
            sample_idx = '0;
            move_steps = STEP_COUNT_RESET;
            errors     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_LOAD)
                begin
                    sel = s_axis_tdata[1:0];
                    st  = s_axis_tdata[25:2];
                    gl  = s_axis_tdata[49:26];
                    if (int'(sel) < AXES)
                    begin
                        start_pos[sel] = st;
                        span[sel]      = {gl[23], gl} - {st[23], st};
                        sample_idx     = '0;
                    end
                end
                else
                    predict_tick();
            end

            if (cfg_valid && cfg_ready)
                move_steps = cfg_data;

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.axis   = m_axis_tdata[1:0];
                got.sample = m_axis_tdata[17:2];
                got.pos    = m_axis_tdata[41:18];
                got.last   = m_axis_tlast;
                got.done   = m_axis_tuser;
                if (planned_samples.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat: axis %0d sample %0d position %0d",
                             $time, got.axis, got.sample, got.pos);
                end
                else
                begin
                    want = planned_samples.pop_front();
                    if (got.axis !== want.axis || got.sample !== want.sample ||
                        got.pos !== want.pos || got.last !== want.last ||
                        got.done !== want.done)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected axis %0d sample %0d position %0d",
                                 $time, want.axis, want.sample, want.pos,
                                 " last %0b done %0b,", want.last, want.done,
                                 " got axis %0d sample %0d position %0d",
                                 got.axis, got.sample, got.pos,
                                 " last %0b done %0b", got.last, got.done);
                    end
                end
            end

            fail_count <= errors;
            pending    <= planned_samples.size();
        end
    end

endmodule

// ===== bench/minimum_jerk_trajectory_test.sv =====
// ----------------------------------------------------------------------------
// minimum_jerk_trajectory_test
// Drives the trajectory generator with a directed sequence of loads and ticks
// around the ends of a move, then with random moves under several step counts
// and several patterns of source gaps and sink stalls. A checker instance
// predicts and compares every output beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module minimum_jerk_trajectory_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mjt_pkg::*;

    localparam int AXES = 4;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = OP_LOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending;

    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;
    int          step_setting  = STEP_COUNT_RESET;

    int          phase_src[4]  = '{0, 59, 0, 29};
    int          phase_sink[4] = '{0, 0, 59, 29};
    int          phase_steps[8] = '{65535, 1, 0, 2, 17, 250, 40, 9};

    minimum_jerk_trajectory #(.AXES(AXES)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    minimum_jerk_trajectory_check #(.AXES(AXES)) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [23:0] draw_position();
        logic [23:0] corners[4] = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF};
        if ($urandom_range(7) == 0)
            return corners[$urandom_range(3)];
        return 24'($urandom);
    endfunction

    task automatic send_beat(input logic op, input logic [1:0] sel,
                             input logic [23:0] st, input logic [23:0] gl);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, gl, st, sel};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic tick();
        send_beat(OP_TICK, 2'($urandom), draw_position(), draw_position());
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // A load beat makes no output, so the block may still be busy after the
    // last expected beat; give it a full tick latency before a register write.
    task automatic settle();
        drain();
        repeat (48) @(posedge clk);
    endtask

    task automatic write_step_count(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        step_setting = value;
    endtask

    task automatic random_moves(input int beats, input logic hold_midway);
        int sent;
        int loads;
        int ticks;
        logic held;
        sent = 0;
        held = 1'b0;
        while (sent < beats)
        begin
            if (hold_midway && !held && sent >= beats / 2)
            begin
                drain();
                held = 1'b1;
            end
            if ($urandom_range(9) < 7)
            begin
                loads = $urandom_range(1, AXES);
                repeat (loads)
                    send_beat(OP_LOAD, 2'($urandom_range(AXES - 1)), draw_position(),
                              draw_position());
                ticks = $urandom_range(1, (step_setting < 12) ? step_setting + 3 : 12);
                repeat (ticks) tick();
                sent += loads + ticks;
            end
            else
            begin
                send_beat(1'($urandom), 2'($urandom), draw_position(), draw_position());
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state, full-range moves in both directions, a one-unit and a
        // zero-length move.
        tick();
        send_beat(OP_LOAD, 2'd0, 24'h800000, 24'h7FFFFF);
        send_beat(OP_LOAD, 2'd1, 24'h7FFFFF, 24'h800000);
        send_beat(OP_LOAD, 2'd2, 24'h000000, 24'hFFFFFF);
        send_beat(OP_LOAD, 2'd3, 24'h000005, 24'h000005);
        repeat (3) tick();

        // Run a short move to its end and hold there.
        settle();
        write_step_count(16'd3);
        send_beat(OP_LOAD, 2'd3, 24'h123456, 24'h9ABCDF);
        repeat (5) tick();

        // Shorten the move below the current index, then try a zero step count.
        settle();
        write_step_count(16'd1);
        tick();
        settle();
        write_step_count(16'd0);
        tick();
        send_beat(OP_LOAD, 2'd2, 24'hFFFFFF, 24'h000000);
        repeat (3) tick();

        settle();
        write_step_count(16'd65535);
        send_beat(OP_LOAD, 2'd0, 24'h7FFFFF, 24'h800000);
        repeat (2) tick();

        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            src_idle_pct   = phase_src[ph % 4];
            sink_stall_pct = phase_sink[ph % 4];
            write_step_count(16'(phase_steps[ph]));
            random_moves(42, ph == 2);
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/mjt_pkg.sv
src/mjt_div.sv
src/mjt_poly.sv
src/mjt_axis_mem.sv
src/minimum_jerk_trajectory.sv
bench/minimum_jerk_trajectory_check.sv
bench/minimum_jerk_trajectory_test.sv
